// File: rtl/uvrm_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// UV region rectangle match package
// Shared types, codes and default sizes for the texture page rectangle lookup.
// ----------------------------------------------------------------------------
package uvrm_pkg;

    localparam int MAX_PAGES_DEF = 16;
    localparam int MAX_RECTS_DEF = 64;
    localparam int MAX_POINTS    = 4;
    localparam int CFG_IDX_W     = 1;
    localparam int CFG_DATA_W    = 3;
    localparam logic [7:0] NO_MATCH = 8'd255;

    typedef enum logic [1:0] {
        OP_SET_PAGE,
        OP_WRITE_RECT,
        OP_QUERY
    } opcode_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_EDGE_TOLERANCE,
        REG_HIT_THRESHOLD
    } cfg_reg_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_PAGE,
        ST_RECT,
        ST_FINISH
    } state_t;

    typedef struct packed {
        logic [1:0]  opcode;
        logic [3:0]  page_slot;
        logic [5:0]  rect_index;
        logic [7:0]  page_id;
        logic [6:0]  rect_count;
        logic [7:0]  rect_x;
        logic [7:0]  rect_y;
        logic [8:0]  rect_w;
        logic [8:0]  rect_h;
        logic [2:0]  point_count;
        logic [63:0] uv_points;
    } in_t;

    typedef struct packed {
        logic [7:0] match_index;
        logic       found;
    } out_t;

endpackage

// File: rtl/uvrm_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Generic simple dual-port RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module uvrm_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             aclk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

// File: rtl/uv_region_rect_match_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// UV region rectangle match, top level
// Texture page table with rectangle lists, searched by packed UV points.
// ----------------------------------------------------------------------------
// A set-page or write-rectangle request leaves the block in its idle state, so
// it is ready again in the next cycle. A query goes to the page state, where
// the page table is searched up to the first valid slot with the matching
// identifier (at most MAX_PAGES slots), then to the rectangle state, where the
// rectangles of that page are scanned up to the first hit (at most MAX_RECTS),
// and then to the finish state, which waits while the previous result still
// waits on the result channel; with no matching page or no rectangles the
// rectangle state is skipped. The page table RAM and the rectangle RAM are
// each read one entry per cycle. The block accepts a query while an earlier
// result still waits on the result channel. There is no clearing pass after
// reset.
module uv_region_rect_match_top #(
    parameter int MAX_PAGES = uvrm_pkg::MAX_PAGES_DEF,
    parameter int MAX_RECTS = uvrm_pkg::MAX_RECTS_DEF
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_valid,
    output logic                            s_ready,
    input  uvrm_pkg::in_t                   s_payload,
    output logic                            m_valid,
    input  logic                            m_ready,
    output uvrm_pkg::out_t                  m_payload,
    input  logic                            cfg_wr_en,
    input  logic [uvrm_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [uvrm_pkg::CFG_DATA_W-1:0] cfg_data
);

    localparam int PW    = (MAX_PAGES > 1) ? $clog2(MAX_PAGES) : 1;
    localparam int RW    = (MAX_RECTS > 1) ? $clog2(MAX_RECTS) : 1;
    localparam int CW    = $clog2(MAX_RECTS + 1);
    localparam int DEPTH = MAX_PAGES * MAX_RECTS;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int PGW   = 8 + CW;

    uvrm_pkg::state_t state_reg, state_next;

    logic [PW-1:0]        p_issue_reg, p_issue_next;
    logic                 p_done_reg, p_done_next;
    logic [PW-1:0]        p_cmp_reg, p_cmp_next;
    logic                 p_cmp_vld_reg, p_cmp_vld_next;
    logic [PW-1:0]        page_reg, page_next;
    logic [CW-1:0]        cnt_reg, cnt_next;
    logic [CW-1:0]        r_issue_reg, r_issue_next;
    logic [RW-1:0]        r_cmp_reg, r_cmp_next;
    logic                 r_cmp_vld_reg, r_cmp_vld_next;
    logic [7:0]           result_reg, result_next;
    logic [7:0]           qid_reg, qid_next;
    logic [2:0]           npts_reg, npts_next;
    logic [63:0]          pts_reg, pts_next;
    logic [MAX_PAGES-1:0] page_valid_reg, page_valid_next;
    logic [2:0]           tol_reg, tol_next;
    logic [1:0]           thr_reg, thr_next;
    logic                 m_valid_reg, m_valid_next;
    uvrm_pkg::out_t       m_data_reg, m_data_next;

    logic           accept;
    logic           slot_ok;
    logic           ridx_ok;
    logic [PW-1:0]  wr_slot;
    logic [CW-1:0]  sat_count;
    logic           page_wr_en;
    logic [PGW-1:0] page_wr_data;
    logic [PGW-1:0] page_rd_data;
    logic           rect_wr_en;
    logic [AW-1:0]  rect_wr_addr;
    logic [31:0]    rect_wr_data;
    logic [AW-1:0]  rect_rd_addr;
    logic [31:0]    rect_rd_data;
    logic           page_hit;
    logic           r_issuing;
    logic [3:0]     pt_hit;
    logic [2:0]     hits;
    logic           rect_hit;

    assign s_ready   = (state_reg == uvrm_pkg::ST_IDLE);
    assign accept    = s_valid && s_ready;
    assign m_valid   = m_valid_reg;
    assign m_payload = m_data_reg;

    assign slot_ok   = 9'(s_payload.page_slot) < 9'(MAX_PAGES);
    assign ridx_ok   = 9'(s_payload.rect_index) < 9'(MAX_RECTS);
    assign wr_slot   = PW'(s_payload.page_slot);
    assign sat_count = (9'(s_payload.rect_count) > 9'(MAX_RECTS)) ?
                       CW'(MAX_RECTS) : CW'(s_payload.rect_count);

    assign page_wr_en   = accept && slot_ok &&
                          (s_payload.opcode == uvrm_pkg::OP_SET_PAGE);
    assign page_wr_data = {s_payload.page_id, sat_count};

    assign rect_wr_en   = accept && slot_ok && ridx_ok &&
                          (s_payload.opcode == uvrm_pkg::OP_WRITE_RECT);
    assign rect_wr_addr = AW'(s_payload.page_slot) * AW'(MAX_RECTS) +
                          AW'(s_payload.rect_index);
    assign rect_wr_data = {s_payload.rect_h[7:0], s_payload.rect_w[7:0],
                           s_payload.rect_y, s_payload.rect_x};
    assign rect_rd_addr = AW'(page_reg) * AW'(MAX_RECTS) + AW'(r_issue_reg[RW-1:0]);

    uvrm_ram #(
        .WIDTH (PGW),
        .DEPTH (MAX_PAGES)
    ) u_page_ram (
        .aclk    (aclk),
        .wr_en   (page_wr_en),
        .wr_addr (wr_slot),
        .wr_data (page_wr_data),
        .rd_addr (p_issue_reg),
        .rd_data (page_rd_data)
    );

    uvrm_ram #(
        .WIDTH (32),
        .DEPTH (DEPTH)
    ) u_rect_ram (
        .aclk    (aclk),
        .wr_en   (rect_wr_en),
        .wr_addr (rect_wr_addr),
        .wr_data (rect_wr_data),
        .rd_addr (rect_rd_addr),
        .rd_data (rect_rd_data)
    );

    assign page_hit = p_cmp_vld_reg && page_valid_reg[p_cmp_reg] &&
                      (page_rd_data[PGW-1 -: 8] == qid_reg);
    assign r_issuing = (r_issue_reg < cnt_reg);

    always_comb begin
        for (int k = 0; k < uvrm_pkg::MAX_POINTS; k++) begin
            pt_hit[k] = (3'(k) < npts_reg) &&
                (10'(pts_reg[16*k +: 8]) + 10'(tol_reg) >= 10'(rect_rd_data[7:0])) &&
                (10'(pts_reg[16*k +: 8]) <= 10'(rect_rd_data[7:0]) +
                    10'(rect_rd_data[23:16]) + 10'(tol_reg)) &&
                (10'(pts_reg[16*k+8 +: 8]) + 10'(tol_reg) >= 10'(rect_rd_data[15:8])) &&
                (10'(pts_reg[16*k+8 +: 8]) <= 10'(rect_rd_data[15:8]) +
                    10'(rect_rd_data[31:24]) + 10'(tol_reg));
        end
    end

    assign hits     = 3'($countones(pt_hit));
    assign rect_hit = r_cmp_vld_reg && (hits > {1'b0, thr_reg});

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= uvrm_pkg::ST_IDLE;
            p_cmp_vld_reg  <= 1'b0;
            r_cmp_vld_reg  <= 1'b0;
            page_valid_reg <= '0;
            tol_reg        <= 3'd1;
            thr_reg        <= 2'd2;
            m_valid_reg    <= 1'b0;
        end else begin
            state_reg      <= state_next;
            p_cmp_vld_reg  <= p_cmp_vld_next;
            r_cmp_vld_reg  <= r_cmp_vld_next;
            page_valid_reg <= page_valid_next;
            tol_reg        <= tol_next;
            thr_reg        <= thr_next;
            m_valid_reg    <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        p_issue_reg <= p_issue_next;
        p_done_reg  <= p_done_next;
        p_cmp_reg   <= p_cmp_next;
        page_reg    <= page_next;
        cnt_reg     <= cnt_next;
        r_issue_reg <= r_issue_next;
        r_cmp_reg   <= r_cmp_next;
        result_reg  <= result_next;
        qid_reg     <= qid_next;
        npts_reg    <= npts_next;
        pts_reg     <= pts_next;
        m_data_reg  <= m_data_next;
    end

    always_comb begin
        state_next      = state_reg;
        p_issue_next    = p_issue_reg;
        p_done_next     = p_done_reg;
        p_cmp_next      = p_cmp_reg;
        p_cmp_vld_next  = p_cmp_vld_reg;
        page_next       = page_reg;
        cnt_next        = cnt_reg;
        r_issue_next    = r_issue_reg;
        r_cmp_next      = r_cmp_reg;
        r_cmp_vld_next  = r_cmp_vld_reg;
        result_next     = result_reg;
        qid_next        = qid_reg;
        npts_next       = npts_reg;
        pts_next        = pts_reg;
        page_valid_next = page_valid_reg;
        tol_next        = tol_reg;
        thr_next        = thr_reg;
        m_valid_next    = m_valid_reg;
        m_data_next     = m_data_reg;

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        if (cfg_wr_en) begin
            unique case (uvrm_pkg::cfg_reg_t'(cfg_index))
                uvrm_pkg::REG_EDGE_TOLERANCE: tol_next = cfg_data[2:0];
                uvrm_pkg::REG_HIT_THRESHOLD:  thr_next = cfg_data[1:0];
                default: ;
            endcase
        end

        if (page_wr_en) begin
            page_valid_next[wr_slot] = 1'b1;
        end

        unique case (state_reg)
            uvrm_pkg::ST_IDLE: begin
                if (accept && (s_payload.opcode == uvrm_pkg::OP_QUERY)) begin
                    qid_next       = s_payload.page_id;
                    npts_next      = (s_payload.point_count > 3'(uvrm_pkg::MAX_POINTS)) ?
                                     3'(uvrm_pkg::MAX_POINTS) : s_payload.point_count;
                    pts_next       = s_payload.uv_points;
                    p_issue_next   = '0;
                    p_done_next    = 1'b0;
                    p_cmp_vld_next = 1'b0;
                    state_next     = uvrm_pkg::ST_PAGE;
                end
            end
            uvrm_pkg::ST_PAGE: begin
                p_cmp_next     = p_issue_reg;
                p_cmp_vld_next = !p_done_reg;
                if (p_issue_reg == PW'(MAX_PAGES - 1)) begin
                    p_done_next = 1'b1;
                end else begin
                    p_issue_next = p_issue_reg + PW'(1);
                end
                if (page_hit) begin
                    page_next      = p_cmp_reg;
                    cnt_next       = page_rd_data[CW-1:0];
                    r_issue_next   = '0;
                    r_cmp_vld_next = 1'b0;
                    p_cmp_vld_next = 1'b0;
                    if (page_rd_data[CW-1:0] == '0) begin
                        result_next = uvrm_pkg::NO_MATCH;
                        state_next  = uvrm_pkg::ST_FINISH;
                    end else begin
                        state_next  = uvrm_pkg::ST_RECT;
                    end
                end else if (p_cmp_vld_reg && (p_cmp_reg == PW'(MAX_PAGES - 1))) begin
                    p_cmp_vld_next = 1'b0;
                    result_next    = uvrm_pkg::NO_MATCH;
                    state_next     = uvrm_pkg::ST_FINISH;
                end
            end
            uvrm_pkg::ST_RECT: begin
                r_cmp_next     = r_issue_reg[RW-1:0];
                r_cmp_vld_next = r_issuing;
                if (r_issuing) begin
                    r_issue_next = r_issue_reg + CW'(1);
                end
                if (rect_hit) begin
                    r_cmp_vld_next = 1'b0;
                    result_next    = 8'(r_cmp_reg);
                    state_next     = uvrm_pkg::ST_FINISH;
                end else if (r_cmp_vld_reg && (CW'(r_cmp_reg) + CW'(1) == cnt_reg)) begin
                    r_cmp_vld_next = 1'b0;
                    result_next    = uvrm_pkg::NO_MATCH;
                    state_next     = uvrm_pkg::ST_FINISH;
                end
            end
            uvrm_pkg::ST_FINISH: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next            = 1'b1;
                    m_data_next.match_index = result_reg;
                    m_data_next.found       = (result_reg != uvrm_pkg::NO_MATCH);
                    state_next              = uvrm_pkg::ST_IDLE;
                end
            end
            default: state_next = uvrm_pkg::ST_IDLE;
        endcase
    end

endmodule

// File: rtl/uvrm_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// UV region rectangle match checker
// Port-level assertions on the request and result channels of the top level.
// ----------------------------------------------------------------------------
module uvrm_checker (
    input logic           aclk,
    input logic           aresetn,
    input logic           s_valid,
    input logic           s_ready,
    input uvrm_pkg::in_t  s_payload,
    input logic           m_valid,
    input logic           m_ready,
    input uvrm_pkg::out_t m_payload
);

    a_found_matches_index: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_payload.found == (m_payload.match_index != uvrm_pkg::NO_MATCH)))
        else $error("found flag disagrees with match index");

    a_result_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> (m_valid && $stable(m_payload)))
        else $error("stalled result changed or dropped");

    a_query_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready && (s_payload.opcode == uvrm_pkg::OP_QUERY)) |=> !s_ready)
        else $error("ready after accepting a query request");

    a_table_write_one_cycle: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready && (s_payload.opcode != uvrm_pkg::OP_QUERY)) |=> s_ready)
        else $error("not ready after a table write request");

endmodule

bind uv_region_rect_match_top uvrm_checker u_checker (.*);
